[src/cws_pkg.sv]
`timescale 1ns / 1ps
// Package for the clock with set mode: request and result structs, field codes,
// digit split, seven-segment table and blink counter step. No dependencies.
package cws_pkg;

    localparam logic [5:0] SecModulus  = 6'd60;
    localparam logic [5:0] MinModulus  = 6'd60;
    localparam logic [4:0] HourModulus = 5'd24;

    localparam logic [5:0] SecReset  = 6'd0;
    localparam logic [5:0] MinReset  = 6'd30;
    localparam logic [4:0] HourReset = 5'd14;

    localparam logic [3:0] LockoutReset = 4'd5;
    localparam logic [3:0] BlinkReset   = 4'd10;

    // Edit field codes
    localparam logic [1:0] EditNone = 2'd0;
    localparam logic [1:0] EditSec  = 2'd1;
    localparam logic [1:0] EditMin  = 2'd2;
    localparam logic [1:0] EditHour = 2'd3;

    // Register indexes (paddr bit 2)
    localparam logic RegLockout = 1'b0;
    localparam logic RegBlink   = 1'b1;

    typedef struct packed {
        logic tick;
        logic mode_button;
        logic set_button;
    } in_t;

    typedef struct packed {
        logic [5:0] sec_value;
        logic [5:0] min_value;
        logic [4:0] hour_value;
        logic [1:0] edit_field;
        logic       ones_dark;
        logic       tens_dark;
        logic [6:0] seg_sec_ones;
        logic [6:0] seg_sec_tens;
        logic [6:0] seg_min_ones;
        logic [6:0] seg_min_tens;
        logic [6:0] seg_hour_ones;
        logic [6:0] seg_hour_tens;
    } out_t;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] ones;
    } digits_t;

    typedef struct packed {
        logic       phase;   // 0: rising (blanking), 1: falling
        logic [3:0] count;
    } blink_t;

    typedef struct packed {
        logic [6:0] ones;
        logic [6:0] tens;
    } seg_pair_t;

    // Split a value below 64 into decimal digits by compare chain
    function automatic digits_t split_digits(input logic [5:0] value);
        digits_t    d;
        logic [5:0] base;
        begin
            priority if (value >= 6'd60) begin
                d.tens = 3'd6;
            end else if (value >= 6'd50) begin
                d.tens = 3'd5;
            end else if (value >= 6'd40) begin
                d.tens = 3'd4;
            end else if (value >= 6'd30) begin
                d.tens = 3'd3;
            end else if (value >= 6'd20) begin
                d.tens = 3'd2;
            end else if (value >= 6'd10) begin
                d.tens = 3'd1;
            end else begin
                d.tens = 3'd0;
            end
            base   = 6'({d.tens, 3'b000}) + 6'({d.tens, 1'b0});
            d.ones = 4'(value - base);
            return d;
        end
    endfunction

    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] s;
        begin
            unique case (digit)
                4'd0:    s = 7'h7E;
                4'd1:    s = 7'h30;
                4'd2:    s = 7'h6D;
                4'd3:    s = 7'h79;
                4'd4:    s = 7'h33;
                4'd5:    s = 7'h5B;
                4'd6:    s = 7'h5F;
                4'd7:    s = 7'h70;
                4'd8:    s = 7'h7F;
                4'd9:    s = 7'h73;
                default: s = 7'h00;
            endcase
            return s;
        end
    endfunction

    // One advance of the triangle counter; the digit is dark if phase was rising
    function automatic blink_t blink_step(input blink_t b, input logic [3:0] half);
        blink_t n;
        begin
            n = b;
            if (!b.phase) begin
                n.count = b.count + 4'd1;
                if (n.count >= half) begin
                    n.phase = 1'b1;
                end
            end else begin
                if (b.count != 4'd0) begin
                    n.count = b.count - 4'd1;
                end
                if (n.count == 4'd0) begin
                    n.phase = 1'b0;
                end
            end
            return n;
        end
    endfunction

endpackage

[src/cws_seg_decode.sv]
`timescale 1ns / 1ps
// Seven-segment decode of one time field: splits the value into decimal
// digits and looks up the a..g patterns. Depends on cws_pkg.
module cws_seg_decode (
    input  logic [5:0]        value,
    output cws_pkg::seg_pair_t segs
);

    cws_pkg::digits_t digits;

    assign digits    = cws_pkg::split_digits(value);
    assign segs.ones = cws_pkg::seg_of(digits.ones);
    assign segs.tens = cws_pkg::seg_of({1'b0, digits.tens});

endmodule

[src/clock_with_set_mode.sv]
`timescale 1ns / 1ps
// Clock with set mode: each accepted request is one pass of the clock loop and
// yields one result in the next cycle from the result register. A new request is
// taken every cycle, also while a result waits, as long as that result is taken
// in the same cycle. Time, edit mode, lockout and blink counters are updated in
// a single pass of logic from the state registers; the sustained rate is one
// request per cycle while results are taken. Reset time is 14:30:00.
// Depends on cws_pkg and cws_seg_decode.
module clock_with_set_mode (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  cws_pkg::in_t      s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output cws_pkg::out_t     m_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [3:0] lockout_passes_reg;
    logic [3:0] blink_half_reg;

    logic [5:0] sec_reg,  sec_next;
    logic [5:0] min_reg,  min_next;
    logic [4:0] hour_reg, hour_next;
    logic [1:0] edit_reg, edit_next;
    logic       lock_active_reg, lock_active_next;
    logic [3:0] lock_count_reg,  lock_count_next;
    cws_pkg::blink_t blink_reg, blink_next, blink_mid;
    logic       ones_dark, tens_dark;

    logic          m_valid_reg;
    cws_pkg::out_t m_data_reg;
    cws_pkg::out_t result;
    cws_pkg::seg_pair_t sec_segs, min_segs, hour_segs;

    logic accept;
    logic cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == cws_pkg::RegBlink) ? {28'd0, blink_half_reg}
                                                       : {28'd0, lockout_passes_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lockout_passes_reg <= cws_pkg::LockoutReset;
            blink_half_reg     <= cws_pkg::BlinkReset;
        end else if (cfg_write) begin
            if (paddr[2] == cws_pkg::RegBlink) begin
                blink_half_reg <= pwdata[3:0];
            end else begin
                lockout_passes_reg <= pwdata[3:0];
            end
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        sec_next         = sec_reg;
        min_next         = min_reg;
        hour_next        = hour_reg;
        edit_next        = edit_reg;
        lock_active_next = lock_active_reg;
        lock_count_next  = lock_count_reg;

        // Tick advances time only outside edit mode
        if (s_data.tick && edit_reg == cws_pkg::EditNone) begin
            sec_next = sec_reg + 6'd1;
            if (sec_next >= cws_pkg::SecModulus) begin
                sec_next = 6'd0;
                min_next = min_reg + 6'd1;
                if (min_next >= cws_pkg::MinModulus) begin
                    min_next  = 6'd0;
                    hour_next = hour_reg + 5'd1;
                end
                if (hour_next >= cws_pkg::HourModulus) begin
                    hour_next = 5'd0;
                end
            end
        end

        // Mode wins over set; set wraps the edited field without carry
        if (!lock_active_reg) begin
            if (s_data.mode_button) begin
                edit_next        = edit_reg + 2'd1;
                lock_active_next = 1'b1;
                lock_count_next  = 4'd0;
            end else if (s_data.set_button && edit_reg != cws_pkg::EditNone) begin
                unique case (edit_reg)
                    cws_pkg::EditSec: begin
                        sec_next = sec_next + 6'd1;
                        if (sec_next >= cws_pkg::SecModulus) sec_next = 6'd0;
                    end
                    cws_pkg::EditMin: begin
                        min_next = min_next + 6'd1;
                        if (min_next >= cws_pkg::MinModulus) min_next = 6'd0;
                    end
                    default: begin
                        hour_next = hour_next + 5'd1;
                        if (hour_next >= cws_pkg::HourModulus) hour_next = 5'd0;
                    end
                endcase
                lock_active_next = 1'b1;
                lock_count_next  = 4'd0;
            end
        end

        // Blink counter advances once per digit of the edited field
        blink_mid  = cws_pkg::blink_step(blink_reg, blink_half_reg);
        ones_dark  = 1'b0;
        tens_dark  = 1'b0;
        blink_next = blink_reg;
        if (edit_next != cws_pkg::EditNone) begin
            ones_dark  = !blink_reg.phase;
            tens_dark  = !blink_mid.phase;
            blink_next = cws_pkg::blink_step(blink_mid, blink_half_reg);
        end

        if (lock_active_next) begin
            if (lock_count_next >= lockout_passes_reg) begin
                lock_active_next = 1'b0;
            end else begin
                lock_count_next = lock_count_next + 4'd1;
            end
        end
    end

    cws_seg_decode u_sec_dec  (.value(sec_next),          .segs(sec_segs));
    cws_seg_decode u_min_dec  (.value(min_next),          .segs(min_segs));
    cws_seg_decode u_hour_dec (.value({1'b0, hour_next}), .segs(hour_segs));

    always_comb begin
        result.sec_value     = sec_next;
        result.min_value     = min_next;
        result.hour_value    = hour_next;
        result.edit_field    = edit_next;
        result.ones_dark     = ones_dark;
        result.tens_dark     = tens_dark;
        result.seg_sec_ones  = sec_segs.ones;
        result.seg_sec_tens  = sec_segs.tens;
        result.seg_min_ones  = min_segs.ones;
        result.seg_min_tens  = min_segs.tens;
        result.seg_hour_ones = hour_segs.ones;
        result.seg_hour_tens = hour_segs.tens;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg         <= cws_pkg::SecReset;
            min_reg         <= cws_pkg::MinReset;
            hour_reg        <= cws_pkg::HourReset;
            edit_reg        <= cws_pkg::EditNone;
            lock_active_reg <= 1'b0;
            lock_count_reg  <= 4'd0;
            blink_reg       <= '0;
        end else if (accept) begin
            sec_reg         <= sec_next;
            min_reg         <= min_next;
            hour_reg        <= hour_next;
            edit_reg        <= edit_next;
            lock_active_reg <= lock_active_next;
            lock_count_reg  <= lock_count_next;
            blink_reg       <= blink_next;
        end
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.sec_value < cws_pkg::SecModulus)
                 && (m_data.min_value < cws_pkg::MinModulus)
                 && (m_data.hour_value < cws_pkg::HourModulus))
        else $error("time field out of range");

    a_dark_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.edit_field == cws_pkg::EditNone)
            |-> (!m_data.ones_dark && !m_data.tens_dark))
        else $error("digit blanked outside edit mode");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted request produced no result");

    a_tick_in_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && edit_reg != cws_pkg::EditNone && !s_data.set_button)
            |=> $stable(sec_reg) && $stable(min_reg) && $stable(hour_reg))
        else $error("time moved while editing without set");

endmodule

[sim/clock_with_set_mode_test.sv]
`timescale 1ns / 1ps
// Testbench for clock_with_set_mode: random and directed loop passes, a cycle-level
// predictor of time, edit mode, lockout and blink flags, and an in-order checker.
// Depends on cws_pkg and the clock_with_set_mode RTL.
module clock_with_set_mode_test;

    localparam int HoldCycles = 150;
    localparam logic [6:0] SegLut [10] = '{
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h73
    };

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    cws_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    cws_pkg::out_t m_data;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    clock_with_set_mode uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock state as the block should hold it
    logic [5:0] tm_sec = cws_pkg::SecReset;
    logic [5:0] tm_min = cws_pkg::MinReset;
    logic [4:0] tm_hour = cws_pkg::HourReset;
    logic [1:0] edit_sel = cws_pkg::EditNone;
    logic       lock_on = 1'b0;
    logic [3:0] lock_cnt = '0;
    logic       blink_ph = 1'b0;
    logic [3:0] blink_cnt = '0;
    logic [3:0] cfg_lockout = cws_pkg::LockoutReset;
    logic [3:0] cfg_half = cws_pkg::BlinkReset;

    cws_pkg::in_t  pass_q[$];
    cws_pkg::out_t want_q[$];
    int   pushed_cnt = 0;
    int   accepted_cnt = 0;
    int   checked_cnt = 0;
    int   mismatch_cnt = 0;
    int   reg_writes = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    logic hold_off = 1'b0;
    logic squeeze_go = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // One advance of the shared triangle counter; returns 1 while blanking
    function automatic logic blink_advance();
        if (!blink_ph) begin
            blink_cnt = blink_cnt + 4'd1;
            if (blink_cnt >= cfg_half) blink_ph = 1'b1;
            return 1'b1;
        end
        if (blink_cnt != 4'd0) blink_cnt = blink_cnt - 4'd1;
        if (blink_cnt == 4'd0) blink_ph = 1'b0;
        return 1'b0;
    endfunction

    function automatic cws_pkg::out_t clock_pass(input cws_pkg::in_t req);
        cws_pkg::out_t r;
        r = '0;
        // ticks count only when no field was being edited at the start of the pass
        if (req.tick && edit_sel == cws_pkg::EditNone) begin
            tm_sec = tm_sec + 6'd1;
            if (tm_sec >= cws_pkg::SecModulus) begin
                tm_sec = '0;
                tm_min = tm_min + 6'd1;
                if (tm_min >= cws_pkg::MinModulus) begin
                    tm_min = '0;
                    tm_hour = tm_hour + 5'd1;
                end
                if (tm_hour >= cws_pkg::HourModulus) tm_hour = '0;
            end
        end
        if (!lock_on) begin
            if (req.mode_button) begin
                edit_sel = edit_sel + 2'd1;
                lock_on = 1'b1;
                lock_cnt = '0;
            end else if (req.set_button && edit_sel != cws_pkg::EditNone) begin
                case (edit_sel)
                    cws_pkg::EditSec:
                        tm_sec = (tm_sec + 6'd1 >= cws_pkg::SecModulus) ? '0
                                                                        : tm_sec + 6'd1;
                    cws_pkg::EditMin:
                        tm_min = (tm_min + 6'd1 >= cws_pkg::MinModulus) ? '0
                                                                        : tm_min + 6'd1;
                    default:
                        tm_hour = (tm_hour + 5'd1 >= cws_pkg::HourModulus) ? '0
                                                                           : tm_hour + 5'd1;
                endcase
                lock_on = 1'b1;
                lock_cnt = '0;
            end
        end
        if (edit_sel != cws_pkg::EditNone) begin
            r.ones_dark = blink_advance();
            r.tens_dark = blink_advance();
        end
        if (lock_on) begin
            if (lock_cnt >= cfg_lockout) lock_on = 1'b0;
            else lock_cnt = lock_cnt + 4'd1;
        end
        r.sec_value     = tm_sec;
        r.min_value     = tm_min;
        r.hour_value    = tm_hour;
        r.edit_field    = edit_sel;
        r.seg_sec_ones  = SegLut[tm_sec % 10];
        r.seg_sec_tens  = SegLut[tm_sec / 10];
        r.seg_min_ones  = SegLut[tm_min % 10];
        r.seg_min_tens  = SegLut[tm_min / 10];
        r.seg_hour_ones = SegLut[tm_hour % 10];
        r.seg_hour_tens = SegLut[tm_hour / 10];
        return r;
    endfunction

    // Request side: offer queued passes, predict each one as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                want_q.push_back(clock_pass(s_data));
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pass_q.size() != 0) begin
                    if ($urandom_range(99) < send_idle_pct) begin
                        send_gap <= $urandom_range(0, 8);
                        s_valid <= 1'b0;
                    end else begin
                        s_data <= pass_q.pop_front();
                        s_valid <= 1'b1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(99) < recv_idle_pct) begin
            recv_gap <= $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [6:0] exp_v,
                               input logic [6:0] got_v);
        if (got_v !== exp_v) begin
            if (mismatch_cnt < 10)
                $display("mismatch in %s of result %0d: expected %0d, got %0d",
                         name, checked_cnt, exp_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        cws_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (want_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("result with no pass pending: %h", m_data);
                mismatch_cnt++;
            end else begin
                want = want_q.pop_front();
                check_field("sec_value", 7'(want.sec_value), 7'(m_data.sec_value));
                check_field("min_value", 7'(want.min_value), 7'(m_data.min_value));
                check_field("hour_value", 7'(want.hour_value), 7'(m_data.hour_value));
                check_field("edit_field", 7'(want.edit_field), 7'(m_data.edit_field));
                check_field("ones_dark", 7'(want.ones_dark), 7'(m_data.ones_dark));
                check_field("tens_dark", 7'(want.tens_dark), 7'(m_data.tens_dark));
                check_field("seg_sec_ones", want.seg_sec_ones, m_data.seg_sec_ones);
                check_field("seg_sec_tens", want.seg_sec_tens, m_data.seg_sec_tens);
                check_field("seg_min_ones", want.seg_min_ones, m_data.seg_min_ones);
                check_field("seg_min_tens", want.seg_min_tens, m_data.seg_min_tens);
                check_field("seg_hour_ones", want.seg_hour_ones, m_data.seg_hour_ones);
                check_field("seg_hour_tens", want.seg_hour_tens, m_data.seg_hour_tens);
                checked_cnt++;
            end
        end
    end

    // Long output stall while requests keep coming, so the input backs up
    initial begin
        wait (squeeze_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #5ms;
        $display("timeout after %0d of %0d results", checked_cnt, pushed_cnt);
        $display("status: fail");
        $finish;
    end

    function automatic logic rbit();
        return 1'($urandom_range(1));
    endfunction

    task automatic queue_pass(input logic t, input logic m, input logic s);
        cws_pkg::in_t p;
        p.tick = t;
        p.mode_button = m;
        p.set_button = s;
        pass_q.push_back(p);
        pushed_cnt++;
    endtask

    task automatic wait_drained();
        while (checked_cnt != pushed_cnt) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == cws_pkg::RegLockout) cfg_lockout = val;
        else cfg_half = val;
        reg_writes++;
    endtask

    // Presses spaced past the lockout window; buttons held inside the window
    // must be ignored. Some loose passes break the spacing on purpose.
    task automatic queue_sessions(input int count);
        int stop_at;
        int pick;
        int k;
        stop_at = pushed_cnt + count;
        while (pushed_cnt < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                queue_pass(rbit(), rbit(), rbit());
            end else begin
                if (pick < 30) queue_pass(rbit(), 1'b1, rbit());
                else if (pick < 90) queue_pass(rbit(), 1'b0, 1'b1);
                else queue_pass(rbit(), 1'b0, 1'b0);
                for (k = 0; k < cfg_lockout; k++) begin
                    if ($urandom_range(3) == 0) queue_pass(rbit(), rbit(), rbit());
                    else queue_pass(rbit(), 1'b0, 1'b0);
                end
                repeat ($urandom_range(0, 2)) queue_pass(rbit(), 1'b0, 1'b0);
            end
        end
    endtask

    // Set 23:59:59 by hand, then tick once for a full carry to midnight.
    // Needs a zero lockout and a drained block.
    task automatic queue_rollover();
        queue_pass(1'b0, 1'b0, 1'b0);
        repeat ((5 - int'(edit_sel)) % 4) queue_pass(1'b0, 1'b1, 1'b0);
        repeat ((119 - int'(tm_sec)) % 60) queue_pass(rbit(), 1'b0, 1'b1);
        queue_pass(rbit(), 1'b1, 1'b0);
        repeat ((119 - int'(tm_min)) % 60) queue_pass(rbit(), 1'b0, 1'b1);
        queue_pass(rbit(), 1'b1, 1'b0);
        repeat ((47 - int'(tm_hour)) % 24) queue_pass(rbit(), 1'b0, 1'b1);
        queue_pass(rbit(), 1'b1, 1'b0);
        queue_pass(1'b1, 1'b0, 1'b0);
        queue_pass(1'b0, 1'b0, 1'b1);
    endtask

    // Step until a field is edited and the blink counter is high in its rising phase
    task automatic catch_rising_blink();
        while (!(edit_sel != cws_pkg::EditNone && !blink_ph && blink_cnt > 4'd2)) begin
            if (edit_sel == cws_pkg::EditNone) queue_pass(1'b0, 1'b1, 1'b0);
            else queue_pass(rbit(), 1'b0, 1'b0);
            wait_drained();
        end
    endtask

    task automatic run_phase(input logic [3:0] lockout, input logic [3:0] half,
                             input int count, input int send_pct, input int recv_pct);
        wait_drained();
        write_reg(cws_pkg::RegLockout, lockout);
        write_reg(cws_pkg::RegBlink, half);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_sessions(count);
    endtask

    initial begin
        wait (aresetn);
        @(posedge aclk);
        send_idle_pct = 20;
        recv_idle_pct = 20;

        // Reset settings: lone buttons, both held, lockout hold and ticks while editing
        queue_pass(1'b0, 1'b0, 1'b0);
        queue_pass(1'b1, 1'b0, 1'b0);
        queue_pass(1'b0, 1'b0, 1'b1);
        queue_pass(1'b1, 1'b1, 1'b1);
        repeat (5) queue_pass(1'b1, 1'b1, 1'b1);
        queue_pass(1'b0, 1'b0, 1'b1);
        repeat (5) queue_pass(1'b1, 1'b0, 1'b0);
        queue_pass(1'b0, 1'b1, 1'b0);
        repeat (5) queue_pass(1'b0, 1'b0, 1'b1);
        queue_pass(1'b1, 1'b1, 1'b0);
        repeat (5) queue_pass(1'b1, 1'b0, 1'b0);
        queue_pass(1'b0, 1'b1, 1'b1);

        // Zero lockout and zero half period, with a full midnight carry
        run_phase(4'd0, 4'd0, 40, 20, 20);
        wait_drained();
        queue_rollover();
        queue_sessions(60);

        // Drop the half period below a rising blink count
        wait_drained();
        write_reg(cws_pkg::RegLockout, 4'd15);
        write_reg(cws_pkg::RegBlink, 4'd15);
        catch_rising_blink();
        write_reg(cws_pkg::RegBlink, 4'd1);
        queue_sessions(100);

        run_phase(4'd15, 4'd15, 250, 30, 30);
        squeeze_go = 1'b1;
        run_phase(4'd1, 4'd1, 200, 0, 0);
        run_phase(4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)), 200, 60, 20);
        run_phase(4'd0, 4'd15, 200, 15, 60);
        run_phase(4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)), 200, 0, 0);

        wait_drained();
        repeat (5) @(posedge aclk);
        if (want_q.size() != 0) begin
            $display("%0d results never arrived", want_q.size());
            mismatch_cnt++;
        end
        $display("ran %0d clock passes, %0d results compared, %0d register writes",
                 accepted_cnt, checked_cnt, reg_writes);
        $display("edit, lockout and blink settings from 0 to 15, one %0d-cycle output stall",
                 HoldCycles);
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("status: fail");
        end
        $finish;
    end

endmodule

[clock_with_set_mode.f]
src/cws_pkg.sv
src/cws_seg_decode.sv
src/clock_with_set_mode.sv
sim/clock_with_set_mode_test.sv
